/* design/dscr_pkg.sv */
// ----------------------------------------------------------------------------
// dscr_pkg: shared types and constants for the stereo capture ring
// Request classes, result kinds, the queued request record and the
// configuration bundle that the front and back parts pass between them.
// ----------------------------------------------------------------------------
`default_nettype none

package dscr_pkg;

  // Stream payload widths (tdata rounded up to whole bytes).
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 176;

  // Request queue between the front and back parts.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_SUMS  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Input command codes carried on in_tuser.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DECIMATION = 1'b0;
  localparam logic CFG_MAX_POINTS = 1'b1;

  // Request classes decided by the front part.
  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_PUSH_END = 2'd1,
    OP_POLL     = 2'd2
  } op_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    op_t                op;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } item_t;

  // Configuration registers as the back part sees them.
  typedef struct packed {
    logic [8:0] decimation;
    logic [6:0] max_points;
  } cfg_t;

endpackage

`default_nettype wire

/* design/dscr_front.sv */
// ----------------------------------------------------------------------------
// dscr_front: request intake and classification
// Accepts stream requests, sorts them into push, push with block end and
// poll, and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module dscr_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [dscr_pkg::IN_DATA_W-1:0] in_tdata,   // left[15:0], right[31:16]
  input  wire logic                           in_tuser,   // cmd
  input  wire logic                           in_tlast,   // block_end
  output logic                                q_valid,
  output dscr_pkg::item_t                     q_item,
  input  wire logic                           q_pop
);

  import dscr_pkg::*;

  item_t             q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              push;
  item_t             cls_item;

  // Sort the incoming request. A poll ignores block end and the samples.
  always_comb begin
    cls_item.left  = $signed(in_tdata[15:0]);
    cls_item.right = $signed(in_tdata[31:16]);
    if (in_tuser == CMD_POLL) begin
      cls_item.op = OP_POLL;
    end else if (in_tlast) begin
      cls_item.op = OP_PUSH_END;
    end else begin
      cls_item.op = OP_PUSH;
    end
  end

  // Queue bookkeeping.
  assign in_tready = (cnt_r != (Q_AW + 1)'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

/* design/dscr_back.sv */
// ----------------------------------------------------------------------------
// dscr_back: sample ring, block sums and poll readout
// Executes queued requests: stores decimated pairs in the ring, keeps the
// block correlation sums, and streams the newest unread points on a poll.
// ----------------------------------------------------------------------------
`default_nettype none

module dscr_back #(
  parameter int unsigned RING_SIZE = 1024,
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dscr_pkg::cfg_t                  cfg,
  input  wire logic                            q_valid,
  input  wire dscr_pkg::item_t                 q_item,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [dscr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);

  import dscr_pkg::*;

  localparam int unsigned AW = $clog2(RING_SIZE);
  localparam int unsigned CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ACC   = 6'b000010,
    S_EMIT  = 6'b000100,
    S_EMPTY = 6'b001000,
    S_READ  = 6'b010000,
    S_SEND  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;

  // Ring storage and pointers.
  logic [15:0]              ring_l [RING_SIZE];
  logic [15:0]              ring_r [RING_SIZE];
  logic [15:0]              mem_l_q, mem_r_q;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]            rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [6:0]               remain_r, remain_nxt;

  // Decimation counter and its remainder unit.
  logic [7:0]               keep_r, keep_nxt;
  logic                     mod_busy_r, mod_busy_nxt;
  logic [8:0]               mod_rem_r, mod_rem_nxt;
  logic [3:0]               mod_step_r, mod_step_nxt;

  // Block sums.
  logic signed [31:0]       prod_x_r, prod_x_nxt;
  logic [30:0]              prod_l_r, prod_l_nxt;
  logic [30:0]              prod_r_r, prod_r_nxt;
  logic signed [43:0]       acc_x_r, acc_x_nxt;
  logic [42:0]              acc_l_r, acc_l_nxt;
  logic [42:0]              acc_rr_r, acc_rr_nxt;
  logic [CW-1:0]            blk_cnt_r, blk_cnt_nxt;
  logic                     end_r, end_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_kind_r, out_kind_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  // Helpers.
  logic [8:0]               dec_eff;
  logic [6:0]               lim_eff;
  logic [8:0]               kp1;
  logic [AW-1:0]            avail;
  logic [16:0]              avail_w;
  logic [6:0]               n_sel;
  logic [16:0]              mod_cand;
  logic [16:0]              mod_rem_w;
  logic [8:0]               mod_rem_step;
  logic [CW-1:0]            cnt_inc;
  logic [CW+12:0]           cnt_ext;
  logic signed [31:0]       mul_x, mul_l, mul_r;
  logic                     out_free;

  // Clamp the configuration registers into their working ranges.
  always_comb begin
    if (cfg.decimation == 9'd0) begin
      dec_eff = 9'd1;
    end else if (cfg.decimation > 9'd256) begin
      dec_eff = 9'd256;
    end else begin
      dec_eff = cfg.decimation;
    end
    if (cfg.max_points == 7'd0) begin
      lim_eff = 7'd1;
    end else if (cfg.max_points > 7'd64) begin
      lim_eff = 7'd64;
    end else begin
      lim_eff = cfg.max_points;
    end
  end

  // Poll sizing: unread points, capped at the point limit.
  assign avail   = wr_idx_r - rd_idx_r;
  assign avail_w = 17'(avail);
  assign n_sel   = (avail_w > 17'(lim_eff)) ? lim_eff : 7'(avail_w);

  // One restoring step of the counter remainder per cycle.
  assign mod_cand     = 17'(dec_eff) << mod_step_r;
  assign mod_rem_w    = 17'(mod_rem_r);
  assign mod_rem_step = (mod_rem_w >= mod_cand) ? 9'(mod_rem_w - mod_cand) : mod_rem_r;

  assign kp1     = {1'b0, keep_r} + 9'd1;
  assign cnt_inc = blk_cnt_r + 1'b1;
  assign cnt_ext = {13'd0, blk_cnt_r};

  // Sample products, registered before they reach the accumulators.
  assign mul_x = q_item.left * q_item.right;
  assign mul_l = q_item.left * q_item.left;
  assign mul_r = q_item.right * q_item.right;

  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = (state_r == S_IDLE) && q_valid && !mod_busy_r;

  // Ring access strobes.
  assign mem_we = q_pop && (q_item.op != OP_POLL) && (keep_r == 8'd0);
  assign mem_re = (state_r == S_READ) ||
                  ((state_r == S_SEND) && out_free && (remain_r != 7'd1));

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    rd_ptr_nxt    = rd_ptr_r;
    remain_nxt    = remain_r;
    keep_nxt      = keep_r;
    mod_busy_nxt  = mod_busy_r;
    mod_rem_nxt   = mod_rem_r;
    mod_step_nxt  = mod_step_r;
    prod_x_nxt    = prod_x_r;
    prod_l_nxt    = prod_l_r;
    prod_r_nxt    = prod_r_r;
    acc_x_nxt     = acc_x_r;
    acc_l_nxt     = acc_l_r;
    acc_rr_nxt    = acc_rr_r;
    blk_cnt_nxt   = blk_cnt_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;

    // The remainder unit runs beside the sequencer.
    if (mod_busy_r) begin
      mod_rem_nxt  = mod_rem_step;
      mod_step_nxt = mod_step_r - 4'd1;
      if (mod_step_r == 4'd0) begin
        mod_busy_nxt = 1'b0;
        keep_nxt     = mod_rem_step[7:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_item.op == OP_POLL) begin
            if (avail == '0) begin
              state_nxt = S_EMPTY;
            end else begin
              rd_ptr_nxt = wr_idx_r - AW'(n_sel);
              remain_nxt = n_sel;
              rd_idx_nxt = wr_idx_r;
              state_nxt  = S_READ;
            end
          end else begin
            prod_x_nxt  = mul_x;
            prod_l_nxt  = mul_l[30:0];
            prod_r_nxt  = mul_r[30:0];
            blk_cnt_nxt = cnt_inc;
            end_nxt     = (q_item.op == OP_PUSH_END) || (cnt_inc >= CW'(MAX_BLOCK));
            if (keep_r == 8'd0) begin
              wr_idx_nxt = wr_idx_r + 1'b1;
            end
            // Counter step; a counter left above a lowered decimation
            // goes through the remainder unit.
            if (kp1 == dec_eff) begin
              keep_nxt = 8'd0;
            end else if (kp1 < dec_eff) begin
              keep_nxt = kp1[7:0];
            end else begin
              mod_busy_nxt = 1'b1;
              mod_rem_nxt  = kp1;
              mod_step_nxt = 4'd8;
            end
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        acc_x_nxt  = acc_x_r + 44'(prod_x_r);
        acc_l_nxt  = acc_l_r + 43'(prod_l_r);
        acc_rr_nxt = acc_rr_r + 43'(prod_r_r);
        state_nxt  = end_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SUMS;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {1'b0, cnt_ext[12:0], acc_rr_r, acc_l_r, acc_x_r, 32'd0};
          acc_x_nxt     = '0;
          acc_l_nxt     = '0;
          acc_rr_nxt    = '0;
          blk_cnt_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EMPTY;
          out_last_nxt  = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_READ: begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
        state_nxt  = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_POINT;
          out_last_nxt  = (remain_r == 7'd1);
          out_data_nxt  = {144'd0, mem_r_q, mem_l_q};
          if (remain_r == 7'd1) begin
            state_nxt = S_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
            remain_nxt = remain_r - 7'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      keep_r      <= '0;
      mod_busy_r  <= 1'b0;
      acc_x_r     <= '0;
      acc_l_r     <= '0;
      acc_rr_r    <= '0;
      blk_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      keep_r      <= keep_nxt;
      mod_busy_r  <= mod_busy_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_l_r     <= acc_l_nxt;
      acc_rr_r    <= acc_rr_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    remain_r   <= remain_nxt;
    mod_rem_r  <= mod_rem_nxt;
    mod_step_r <= mod_step_nxt;
    prod_x_r   <= prod_x_nxt;
    prod_l_r   <= prod_l_nxt;
    prod_r_r   <= prod_r_nxt;
    end_r      <= end_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  // Ring memory: one write port, one registered read port. A poll only
  // reads entries written since reset, so the ring needs no clearing pass.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_l[wr_idx_r] <= q_item.left;
      ring_r[wr_idx_r] <= q_item.right;
    end
    if (mem_re) begin
      mem_l_q <= ring_l[rd_ptr_r];
      mem_r_q <= ring_r[rd_ptr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* design/decimating_stereo_capture_ring_core.sv */
// ----------------------------------------------------------------------------
// decimating_stereo_capture_ring_core: decimating stereo capture ring
// Stores every Nth stereo pair in a ring, reports per-block L*R, L*L and
// R*R sums, and returns the newest unread points on a poll.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Carries
//  in_      slave      tvalid/tready      push (pair, block end) or poll
//  out_     master     tvalid/tready      ring point, block sums or empty poll
//  cfg_     write      cfg_we             decimation (0), max_points (1)
//
// A push passes through the back part as product, then accumulate, and then
// a sums output when it closes a block. A poll reads the ring, then sends one
// point per cycle from the ring's registered read port while out_tready holds.
// A push that finds the counter above a lowered decimation starts a remainder
// step that holds off the next request. Reset is synchronous and needs no
// ring sweep; a four-request queue lets intake continue while results stall.
//
`default_nettype none

module decimating_stereo_capture_ring_core #(
  parameter int unsigned RING_SIZE = 1024,
  parameter int unsigned MAX_BLOCK = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dscr_pkg::IN_DATA_W-1:0]  in_tdata,   // left[15:0], right[31:16]
  input  wire logic                            in_tuser,   // cmd
  input  wire logic                            in_tlast,   // block_end
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // point_left[15:0], point_right[31:16], sum_cross[75:32],
  // sum_left_sq[118:76], sum_right_sq[161:119], block_count[174:162], zero[175]
  output logic [dscr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                           out_tuser,  // kind
  output logic                                 out_tlast,  // last
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [8:0]                      cfg_wdata
);

  import dscr_pkg::*;

  cfg_t   cfg_r;
  cfg_t   cfg_nxt;
  logic   q_valid;
  item_t  q_item;
  logic   q_pop;

  // Configuration registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DECIMATION: cfg_nxt.decimation = cfg_wdata;
        CFG_MAX_POINTS: cfg_nxt.max_points = cfg_wdata[6:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decimation <= 9'd4;
      cfg_r.max_points <= 7'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Request intake and queue.
  dscr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Ring, sums and readout.
  dscr_back #(
    .RING_SIZE (RING_SIZE),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
